// ===== hdl/zoh_pkg.sv =====
// Shared types and constants for the zero-order-hold upsampler.
package zoh_pkg;

  localparam int RATE_W = 16;
  localparam int PCM_W  = 16;
  localparam int RUN_W  = 4;

  localparam logic [RATE_W:0]   OUT_RATE  = 17'd48000;
  localparam logic [31:0]       RATE_MIN  = 32'd4000;
  localparam logic [31:0]       RATE_MAX  = 32'd48000;
  localparam logic [RATE_W-1:0] RATE_DEF  = 16'd8000;
  localparam logic [RUN_W-1:0]  MAX_RUN   = 4'd12;

  localparam logic [1:0] CFG_HEADER_RATE   = 2'd0;
  localparam logic [1:0] CFG_HEADER_COUNT  = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_BYTES = 2'd2;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic [PCM_W-1:0] pcm;
    logic             run_last;
    logic             stream_end;
  } frame_t;

endpackage

// ===== hdl/zoh_div.sv =====
// Restoring divider, one quotient bit per cycle, for the stream frame total.
module zoh_div #(
  parameter int DW = 40
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [DW-1:0]              dividend,
  input  logic [zoh_pkg::RATE_W-1:0] divisor,
  output logic                       busy,
  output logic [DW-1:0]              quotient
);

  localparam int CW = $clog2(DW + 1);

  logic                       busy_r, busy_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [DW-1:0]              dvd_r, dvd_nxt;
  logic [zoh_pkg::RATE_W-1:0] rem_r, rem_nxt;
  logic [zoh_pkg::RATE_W-1:0] dsr_r, dsr_nxt;
  logic [zoh_pkg::RATE_W:0]   trial;
  logic                       ge;

  // The dividend shifts out at the top while quotient bits shift in at the bottom.
  always_comb begin
    trial    = {rem_r, dvd_r[DW-1]};
    ge       = trial >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(DW);
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? zoh_pkg::RATE_W'(trial - {1'b0, dsr_r}) : trial[zoh_pkg::RATE_W-1:0];
      dvd_nxt = {dvd_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = busy_r;
  assign quotient = dvd_r;

endmodule

// ===== hdl/zoh_seq.sv =====
// Frame sequencer: steps the phase accumulator once per emitted output frame.
module zoh_seq #(
  parameter int CB = 24
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [7:0]                 sample,
  input  logic [zoh_pkg::RATE_W-1:0] rate,
  input  logic [CB-1:0]              count,
  input  logic [CB+3:0]              total,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_stall,
  output zoh_pkg::frame_t            out_beat
);

  localparam int FW = CB + 4;

  zoh_pkg::seq_state_t        state_r, state_nxt;
  logic [CB-1:0]              idx_r, idx_nxt;
  logic [FW-1:0]              frame_r, frame_nxt;
  logic [zoh_pkg::RATE_W-1:0] phase_r, phase_nxt;
  logic [zoh_pkg::RUN_W-1:0]  n_r, n_nxt;
  logic [zoh_pkg::PCM_W-1:0]  pcm_r, pcm_nxt;
  logic                       out_valid_r, out_valid_nxt;
  zoh_pkg::frame_t            beat_r, beat_nxt;
  logic [zoh_pkg::RATE_W:0]   sum;
  logic                       wrap;
  logic                       slot_free;
  logic                       emit;
  logic                       at_end;
  logic                       last;

  always_comb begin
    sum       = {1'b0, phase_r} + {1'b0, rate};
    wrap      = sum >= zoh_pkg::OUT_RATE;
    slot_free = !out_valid_r || !out_stall;
    at_end    = (frame_r + 1'b1) == total;
    last      = wrap || (n_r == zoh_pkg::MAX_RUN - 1'b1) || at_end;

    state_nxt = state_r;
    idx_nxt   = idx_r;
    frame_nxt = frame_r;
    phase_nxt = phase_r;
    n_nxt     = n_r;
    pcm_nxt   = pcm_r;
    emit      = 1'b0;

    unique case (state_r)
      zoh_pkg::SEQ_IDLE: begin
        if (start) begin
          pcm_nxt   = {~sample[7], sample[6:0], 8'h00};
          n_nxt     = '0;
          state_nxt = zoh_pkg::SEQ_RUN;
        end
      end
      zoh_pkg::SEQ_RUN: begin
        if (idx_r >= count) begin
          // Samples beyond the count are dropped without emitting a frame or advancing the index.
          state_nxt = zoh_pkg::SEQ_IDLE;
        end else if (frame_r >= total) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = zoh_pkg::SEQ_IDLE;
        end else if (slot_free) begin
          emit      = 1'b1;
          frame_nxt = frame_r + 1'b1;
          phase_nxt = wrap ? zoh_pkg::RATE_W'(sum - zoh_pkg::OUT_RATE)
                           : sum[zoh_pkg::RATE_W-1:0];
          n_nxt     = n_r + 1'b1;
          if (last) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = zoh_pkg::SEQ_IDLE;
          end
        end
      end
      default: state_nxt = zoh_pkg::SEQ_IDLE;
    endcase

    out_valid_nxt = emit || (out_valid_r && out_stall);
    beat_nxt      = beat_r;
    if (emit) begin
      beat_nxt.pcm        = pcm_r;
      beat_nxt.run_last   = last;
      beat_nxt.stream_end = at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= zoh_pkg::SEQ_IDLE;
      idx_r       <= '0;
      frame_r     <= '0;
      phase_r     <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      frame_r     <= frame_nxt;
      phase_r     <= phase_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pcm_r  <= pcm_nxt;
    beat_r <= beat_nxt;
  end

  assign busy      = state_r != zoh_pkg::SEQ_IDLE;
  assign out_valid = out_valid_r;
  assign out_beat  = beat_r;

endmodule

// ===== hdl/pcm8_to_48k_zero_order_hold_upsampler_top.sv =====
// Top level: 8-bit mono to 48 kHz stereo zero-order-hold upsampler.
// The first frame of a sample is registered into the output beat once the sequencer is in its run state.
// A sample producing k frames (1 to 12) holds the input stalled until its last frame is emitted,
// the phase accumulator stepping one frame per cycle while the output slot is free; dropped samples also stall it.
// Reset and every config write start the frame-total divider, which keeps in_stall
// high while the division is pending or running; reset also clears the stream counters.
module pcm8_to_48k_zero_order_hold_upsampler_top #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_sample_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_left_pcm,
  output logic [15:0] out_right_pcm,
  output logic        out_run_last,
  output logic        out_stream_end
);

  localparam int DW = COUNT_BITS + zoh_pkg::RATE_W;
  localparam int FW = COUNT_BITS + 4;
  localparam logic [32:0] CAP = 33'((34'd1 << COUNT_BITS) - 34'd1);

  logic [31:0]                hdr_rate_r, hdr_rate_nxt;
  logic [31:0]                hdr_count_r, hdr_count_nxt;
  logic [23:0]                pay_bytes_r, pay_bytes_nxt;
  logic                       pend_r, pend_nxt;
  logic [zoh_pkg::RATE_W-1:0] rate_eff;
  logic [31:0]                count_sel;
  logic [COUNT_BITS-1:0]      count_eff;
  logic [DW-1:0]              product;
  logic                       div_start;
  logic                       div_busy;
  logic [DW-1:0]              quotient;
  logic                       seq_busy;
  logic                       in_accept;
  zoh_pkg::frame_t            beat;

  always_comb begin
    hdr_rate_nxt  = hdr_rate_r;
    hdr_count_nxt = hdr_count_r;
    pay_bytes_nxt = pay_bytes_r;
    if (cfg_we) begin
      unique case (cfg_index)
        zoh_pkg::CFG_HEADER_RATE:   hdr_rate_nxt  = cfg_wdata;
        zoh_pkg::CFG_HEADER_COUNT:  hdr_count_nxt = cfg_wdata;
        zoh_pkg::CFG_PAYLOAD_BYTES: pay_bytes_nxt = cfg_wdata[23:0];
        default: ;
      endcase
    end
    div_start = pend_r && !div_busy;
    pend_nxt  = cfg_we || (pend_r && !div_start);
  end

  always_comb begin
    if (hdr_rate_r < zoh_pkg::RATE_MIN || hdr_rate_r > zoh_pkg::RATE_MAX) begin
      rate_eff = zoh_pkg::RATE_DEF;
    end else begin
      rate_eff = hdr_rate_r[zoh_pkg::RATE_W-1:0];
    end
    if (hdr_count_r == 32'd0 || hdr_count_r > {8'd0, pay_bytes_r}) begin
      count_sel = {8'd0, pay_bytes_r};
    end else begin
      count_sel = hdr_count_r;
    end
    if ({1'b0, count_sel} > CAP) begin
      count_eff = COUNT_BITS'(CAP);
    end else begin
      count_eff = COUNT_BITS'(count_sel);
    end
    product = DW'(count_eff) * DW'(zoh_pkg::OUT_RATE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_rate_r  <= 32'(zoh_pkg::RATE_DEF);
      hdr_count_r <= '0;
      pay_bytes_r <= '0;
      pend_r      <= 1'b1;
    end else begin
      hdr_rate_r  <= hdr_rate_nxt;
      hdr_count_r <= hdr_count_nxt;
      pay_bytes_r <= pay_bytes_nxt;
      pend_r      <= pend_nxt;
    end
  end

  zoh_div #(
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (rate_eff),
    .busy     (div_busy),
    .quotient (quotient)
  );

  assign in_stall  = pend_r || div_busy || seq_busy;
  assign in_accept = in_valid && !in_stall;

  zoh_seq #(
    .CB(COUNT_BITS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (in_accept),
    .sample    (in_sample_byte),
    .rate      (rate_eff),
    .count     (count_eff),
    .total     (quotient[FW-1:0]),
    .busy      (seq_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (beat)
  );

  assign out_left_pcm   = beat.pcm;
  assign out_right_pcm  = beat.pcm;
  assign out_run_last   = beat.run_last;
  assign out_stream_end = beat.stream_end;

endmodule

// ===== hdl/zoh_chk.sv =====
// Port-level checker for the upsampler top level, with its bind.
module zoh_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_left_pcm,
  input logic [15:0] out_right_pcm,
  input logic        out_run_last,
  input logic        out_stream_end
);

  // The frame total is recomputed after reset, so input must be held off.
  a_stall_after_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("in_stall low right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_left_pcm) && $stable(out_run_last))
    else $error("stalled output beat changed");

  a_stereo_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_pcm == out_right_pcm)
    else $error("left and right channels differ");

  a_low_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_left_pcm[7:0] == 8'h00)
    else $error("sample not scaled by 256");

  a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stream_end |-> out_run_last)
    else $error("stream end beat does not close its run");

endmodule

bind pcm8_to_48k_zero_order_hold_upsampler_top zoh_chk u_zoh_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_left_pcm   (out_left_pcm),
  .out_right_pcm  (out_right_pcm),
  .out_run_last   (out_run_last),
  .out_stream_end (out_stream_end)
);
